/* rtl/tcrd_pkg.sv */
// Shared types, codes and float helpers for the telemetry coalescer.
`default_nettype none
package tcrd_pkg;

  localparam logic [31:0] QNAN = 32'h7FC0_0000;

  typedef enum logic [1:0] {
    ACT_FRAME   = 2'd0,
    ACT_CLEAR   = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_STICKY = 2'd0,
    REG_SLACK  = 2'd1,
    REG_STRIP  = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] sender_ms;
    logic [31:0] arrival_ms;
    logic [15:0] frame_flags;
    logic [31:0] accel_peak;
    logic [31:0] gyro_peak;
    logic [31:0] linear_peak;
    logic [15:0] change_bits;
  } in_beat_t;

  typedef struct packed {
    logic        is_ended;
    logic        restart_seen;
    logic [31:0] out_sender_ms;
    logic [15:0] out_flags;
    logic [31:0] out_accel_peak;
    logic [31:0] out_gyro_peak;
    logic [31:0] out_linear_peak;
    logic [15:0] out_change_bits;
    logic [31:0] pending_count;
    logic [31:0] restart_count;
    logic [31:0] dropped_count;
    logic        last;
  } out_beat_t;

  function automatic logic is_nan(logic [31:0] b);
    return b[30:0] > 31'h7F80_0000;
  endfunction

  // a > b for non-NaN singles
  function automatic logic fgt(logic [31:0] a, logic [31:0] b);
    logic both_zero;
    both_zero = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
    if (both_zero) return 1'b0;
    if (a[31] != b[31]) return ~a[31];
    if (!a[31]) return a[30:0] > b[30:0];
    return a[30:0] < b[30:0];
  endfunction

  function automatic logic [31:0] peak_max(logic [31:0] acc, logic [31:0] smp);
    if (is_nan(smp)) return acc;
    if (is_nan(acc)) return smp;
    return fgt(smp, acc) ? smp : acc;
  endfunction

  function automatic logic [31:0] sat_inc(logic [31:0] x);
    return (x == 32'hFFFF_FFFF) ? x : x + 32'd1;
  endfunction

endpackage
`default_nettype wire

/* rtl/tcrd_if.sv */
// Valid/ready channel interfaces for input and result beats.
`default_nettype none
interface tcrd_in_if;
  import tcrd_pkg::*;
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tcrd_out_if;
  import tcrd_pkg::*;
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/telemetry_coalescer_restart_detect.sv */
// Telemetry coalescer with sender restart detection, top level.
//
// Channel | Dir | Handshake   | Beat
// in_ch   | in  | valid/ready | one frame or action
// out_ch  | out | valid/ready | status or ended-session snapshot, last marks end
// apb     | in  | psel/penable| sticky_mask, clock_slack_ms, strip_mask
//
// An accepted beat is registered, processed in the next cycle and its one or
// two results go into a four-entry result queue. A new beat is taken whenever
// the queue has room for the beat in flight plus this one, so a beat can be
// accepted while the previous one is still being processed.
// Synchronous reset clears the session state and queue pointers and loads the
// config registers with their defaults; stalls on out_ch back up into in_ch.
`default_nettype none
module telemetry_coalescer_restart_detect (
  input  wire logic        clk,
  input  wire logic        rst,
  tcrd_in_if.sink          in_ch,
  tcrd_out_if.source       out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import tcrd_pkg::*;

  logic [15:0] sticky_mask, clock_slack_ms, strip_mask;

  logic        v;
  in_beat_t    iq;

  logic        has_data, ended_pending;
  logic [31:0] last_sender_ms, last_arrival_ms;
  logic [15:0] latest_flags, latest_changes, coal_flags, coal_changes;
  logic [31:0] latest_pk [3];
  logic [31:0] coal_pk [3];
  logic [31:0] unsent, restarts, dropped;
  logic [31:0] end_sender;
  logic [15:0] end_flags, end_changes;
  logic [31:0] end_pk [3];

  out_beat_t   fifo [4];
  logic [1:0]  wp, rp;
  logic [2:0]  cnt;

  // config port
  assign pready = 1'b1;
  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_STICKY: prdata = {16'd0, sticky_mask};
      REG_SLACK:  prdata = {16'd0, clock_slack_ms};
      REG_STRIP:  prdata = {16'd0, strip_mask};
      default:    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sticky_mask    <= 16'hFFFF;
      clock_slack_ms <= 16'd100;
      strip_mask     <= 16'd0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_STICKY: sticky_mask    <= pwdata[15:0];
        REG_SLACK:  clock_slack_ms <= pwdata[15:0];
        REG_STRIP:  strip_mask     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // input register
  logic in_acc;
  assign in_ch.ready = ({1'b0, cnt[1:0]} + (v ? 3'd2 : 3'd0) + (cnt[2] ? 3'd4 : 3'd0)) <= 3'd2;
  assign in_acc = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) v <= 1'b0;
    else v <= in_acc;
    if (in_acc) iq <= in_ch.data;
  end

  // processing
  logic [31:0]        step, elapsed;
  logic signed [32:0] skew, slack;
  logic               boundary, take;
  logic [31:0]        in_pk [3];
  logic [31:0]        stat_pk [3];
  logic [31:0]        base_pk [3];
  logic [31:0]        coal_pk_next [3];
  logic [31:0]        fst_pk [3];
  logic [31:0]        restarts_b, dropped_b;
  logic [15:0]        cur_flags, cur_changes, base_flags, base_changes;
  logic [31:0]        base_unsent;
  out_beat_t          r0, r1;
  logic               two;

  always_comb begin
    in_pk[0] = iq.accel_peak;
    in_pk[1] = iq.gyro_peak;
    in_pk[2] = iq.linear_peak;
    step    = iq.sender_ms - last_sender_ms;
    elapsed = iq.arrival_ms - last_arrival_ms;
    skew    = $signed({1'b0, step}) - $signed({1'b0, elapsed});
    slack   = $signed({17'd0, clock_slack_ms}) + $signed({11'd0, elapsed[31:10]});
    boundary = (action_t'(iq.action) == ACT_FRAME) && has_data &&
               (step[31] || (skew > slack) || (skew < -slack));
    take = boundary && (unsent != 32'd0) && !ended_pending;
    restarts_b = boundary ? sat_inc(restarts) : restarts;
    dropped_b  = (boundary && (unsent != 32'd0) && ended_pending) ? sat_inc(dropped) : dropped;
    cur_flags   = latest_flags | coal_flags;
    cur_changes = latest_changes | coal_changes;
    base_flags   = boundary ? 16'd0 : coal_flags;
    base_changes = boundary ? 16'd0 : coal_changes;
    base_unsent  = boundary ? 32'd0 : unsent;
    for (int i = 0; i < 3; i++) begin
      stat_pk[i]      = peak_max(latest_pk[i], coal_pk[i]);
      base_pk[i]      = boundary ? QNAN : coal_pk[i];
      coal_pk_next[i] = peak_max(base_pk[i], in_pk[i]);
      fst_pk[i]       = peak_max(in_pk[i], coal_pk_next[i]);
    end

    // snapshot result (frame with restart), using counters after session end
    r0.is_ended        = 1'b1;
    r0.restart_seen    = 1'b1;
    r0.out_sender_ms   = last_sender_ms;
    r0.out_flags       = cur_flags & ~strip_mask;
    r0.out_accel_peak  = stat_pk[0];
    r0.out_gyro_peak   = stat_pk[1];
    r0.out_linear_peak = stat_pk[2];
    r0.out_change_bits = cur_changes;
    r0.pending_count   = 32'd0;
    r0.restart_count   = restarts_b;
    r0.dropped_count   = dropped_b;
    r0.last            = 1'b0;
    two = 1'b0;

    // default: status of the current state
    r1.is_ended        = 1'b0;
    r1.restart_seen    = 1'b0;
    r1.out_sender_ms   = last_sender_ms;
    r1.out_flags       = cur_flags;
    r1.out_accel_peak  = stat_pk[0];
    r1.out_gyro_peak   = stat_pk[1];
    r1.out_linear_peak = stat_pk[2];
    r1.out_change_bits = cur_changes;
    r1.pending_count   = unsent;
    r1.restart_count   = restarts;
    r1.dropped_count   = dropped;
    r1.last            = 1'b1;

    case (action_t'(iq.action))
      ACT_FRAME: begin
        two                = take;
        r1.restart_seen    = boundary;
        r1.out_sender_ms   = iq.sender_ms;
        r1.out_flags       = iq.frame_flags | base_flags | (iq.frame_flags & sticky_mask);
        r1.out_accel_peak  = fst_pk[0];
        r1.out_gyro_peak   = fst_pk[1];
        r1.out_linear_peak = fst_pk[2];
        r1.out_change_bits = iq.change_bits | base_changes;
        r1.pending_count   = sat_inc(base_unsent);
        r1.restart_count   = restarts_b;
        r1.dropped_count   = dropped_b;
      end
      ACT_CLEAR: begin
        r1.out_flags       = latest_flags;
        r1.out_accel_peak  = latest_pk[0];
        r1.out_gyro_peak   = latest_pk[1];
        r1.out_linear_peak = latest_pk[2];
        r1.out_change_bits = latest_changes;
        r1.pending_count   = 32'd0;
      end
      ACT_RELEASE: begin
        if (ended_pending) begin
          r1.is_ended        = 1'b1;
          r1.out_sender_ms   = end_sender;
          r1.out_flags       = end_flags;
          r1.out_accel_peak  = end_pk[0];
          r1.out_gyro_peak   = end_pk[1];
          r1.out_linear_peak = end_pk[2];
          r1.out_change_bits = end_changes;
        end
      end
      default: ;
    endcase
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      has_data        <= 1'b0;
      ended_pending   <= 1'b0;
      last_sender_ms  <= 32'd0;
      last_arrival_ms <= 32'd0;
      latest_flags    <= 16'd0;
      latest_changes  <= 16'd0;
      coal_flags      <= 16'd0;
      coal_changes    <= 16'd0;
      unsent          <= 32'd0;
      restarts        <= 32'd0;
      dropped         <= 32'd0;
      end_sender      <= 32'd0;
      end_flags       <= 16'd0;
      end_changes     <= 16'd0;
      for (int i = 0; i < 3; i++) begin
        latest_pk[i] <= QNAN;
        coal_pk[i]   <= QNAN;
        end_pk[i]    <= QNAN;
      end
    end else if (v) begin
      case (action_t'(iq.action))
        ACT_FRAME: begin
          if (take) begin
            ended_pending <= 1'b1;
            end_sender    <= last_sender_ms;
            end_flags     <= cur_flags & ~strip_mask;
            end_changes   <= cur_changes;
            for (int i = 0; i < 3; i++) end_pk[i] <= stat_pk[i];
          end
          restarts        <= restarts_b;
          dropped         <= dropped_b;
          has_data        <= 1'b1;
          last_sender_ms  <= iq.sender_ms;
          last_arrival_ms <= iq.arrival_ms;
          latest_flags    <= iq.frame_flags;
          latest_changes  <= iq.change_bits;
          coal_flags      <= base_flags | (iq.frame_flags & sticky_mask);
          coal_changes    <= base_changes | iq.change_bits;
          unsent          <= sat_inc(base_unsent);
          for (int i = 0; i < 3; i++) begin
            latest_pk[i] <= in_pk[i];
            coal_pk[i]   <= coal_pk_next[i];
          end
        end
        ACT_CLEAR: begin
          coal_flags   <= 16'd0;
          coal_changes <= 16'd0;
          unsent       <= 32'd0;
          for (int i = 0; i < 3; i++) coal_pk[i] <= QNAN;
        end
        ACT_RELEASE: ended_pending <= 1'b0;
        default: ;
      endcase
    end
  end

  // result queue
  logic push1, pop;
  assign push1 = v;
  assign pop   = out_ch.valid && out_ch.ready;
  assign out_ch.valid = cnt != 3'd0;
  assign out_ch.data  = fifo[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 2'd0;
      rp  <= 2'd0;
      cnt <= 3'd0;
    end else begin
      if (push1) wp <= wp + (two ? 2'd2 : 2'd1);
      if (pop) rp <= rp + 2'd1;
      cnt <= cnt + (push1 ? (two ? 3'd2 : 3'd1) : 3'd0) - (pop ? 3'd1 : 3'd0);
    end
    if (push1) begin
      if (two) begin
        fifo[wp]        <= r0;
        fifo[wp + 2'd1] <= r1;
      end else begin
        fifo[wp] <= r1;
      end
    end
  end

endmodule
`default_nettype wire
